// ===== hdl/grid_monotone_path_counter_assert.svh =====
// Assertion macros for the grid monotone path counter.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef GRID_MONOTONE_PATH_COUNTER_ASSERT_SVH
`define GRID_MONOTONE_PATH_COUNTER_ASSERT_SVH

// Same-cycle implication.
`define GMPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GMPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gmpc_pkg.sv =====
// Shared types and constants of the grid monotone path counter.
// No dependencies.
package gmpc_pkg;

  localparam int COUNT_W   = 28;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 2'd0,
    REG_GRID_COLS = 2'd1
  } gmpc_reg_t;

  localparam logic [CFG_W-1:0] GRID_ROWS_RESET = 5'd8;
  localparam logic [CFG_W-1:0] GRID_COLS_RESET = 5'd9;

  // Control that travels with a cell from the read stage to the update stage.
  typedef struct packed {
    logic start;
    logic top_row;
    logic first_col;
    logic blocked;
    logic last;
    logic single;
  } gmpc_s1_t;

endpackage

// ===== hdl/gmpc_in_if.sv =====
// Cell request channel of the grid monotone path counter.
// Depends on nothing.
interface gmpc_in_if;
  logic valid;
  logic ready;
  logic blocked;

  modport source (output valid, output blocked, input ready);
  modport sink   (input valid, input blocked, output ready);
endinterface

// ===== hdl/gmpc_out_if.sv =====
// Result request channel of the grid monotone path counter.
// Depends on gmpc_pkg.
interface gmpc_out_if
  import gmpc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] path_count;

  modport source (output valid, output path_count, input ready);
  modport sink   (input valid, input path_count, output ready);
endinterface

// ===== hdl/gmpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gmpc_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/grid_monotone_path_counter.sv =====
// Grid monotone path counter, top level.
// Depends on gmpc_pkg, gmpc_in_if, gmpc_out_if, gmpc_ram and the assert header.
//
// Cells come in on in_ch in row-major order, one blocked flag per request.
// After the last cell of a grid_rows x grid_cols grid, one path_count
// request goes out on out_ch; no other cell gives a result. cfg_we writes
// grid_rows (index 0) or grid_cols (index 1) from cfg_wdata; any write also
// restarts the grid, so the next cell is the start cell.
// Throughput: one cell per cycle while no last cell waits for buffer room.
// The column store is a RAM read in the accept cycle and written back in
// the next cycle; a read of the entry being written in that cycle is
// forwarded, so single-column grids run at full rate too. Results queue in
// a two-entry buffer (output register plus skid register); a last cell is
// taken only when the buffer is sure to have room for it, so 1x1 grids also
// run at one cell per cycle while out_ch is ready. With the buffer empty, the
// last cell passes the update stage, then its result the output register.
// While out_ch is stalled, cells that are not last keep flowing in; a last
// cell waits once two results are held or on their way.
// Reset (rst_n low at a clock edge) sets grid_rows to 8, grid_cols to 9,
// restarts the grid and drops any result held in the buffer.
module grid_monotone_path_counter
  import gmpc_pkg::*;
#(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  gmpc_in_if.sink              in_ch,
  gmpc_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  `include "grid_monotone_path_counter_assert.svh"

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam logic [CFG_W-1:0] MAX_R = CFG_W'(MAX_ROWS);
  localparam logic [CFG_W-1:0] MAX_C = CFG_W'(MAX_COLS);
  localparam logic [CFG_W-1:0] ONE   = CFG_W'(1);

  logic [CFG_W-1:0]   grid_rows_r, grid_cols_r;
  logic [CFG_W-1:0]   rows_eff, cols_eff;
  logic [RW-1:0]      row_r, row_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic               last_row, last_col, in_last, accept;
  gmpc_s1_t           s1_r, s1_nxt;
  logic               s1_valid_r;
  logic [CW-1:0]      s1_col_r;
  logic [COUNT_W-1:0] left_r, up, left, count, ram_rdata;
  logic               fwd_hit_r;
  logic [COUNT_W-1:0] fwd_data_r;
  logic               res_push, res_pop;
  logic [COUNT_W-1:0] res_count;
  logic [1:0]         res_load;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  logic [COUNT_W-1:0] skid_count_r, skid_count_nxt;

  // Size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= GRID_ROWS_RESET;
      grid_cols_r <= GRID_COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GRID_ROWS: grid_rows_r <= cfg_wdata;
        REG_GRID_COLS: grid_cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign rows_eff = (grid_rows_r == '0) ? ONE : ((grid_rows_r > MAX_R) ? MAX_R : grid_rows_r);
  assign cols_eff = (grid_cols_r == '0) ? ONE : ((grid_cols_r > MAX_C) ? MAX_C : grid_cols_r);

  assign last_row = (CFG_W'(row_r) + ONE) == rows_eff;
  assign last_col = (CFG_W'(col_r) + ONE) == cols_eff;
  assign in_last  = last_row && last_col;

  // worst-case buffer fill once the result now in the update stage has landed
  assign res_push  = s1_valid_r && s1_r.last;
  assign res_pop   = out_valid_r && out_ch.ready;
  assign res_load  = 2'(out_valid_r) + 2'(skid_valid_r) + 2'(res_push) - 2'(res_pop);

  assign in_ch.ready = !in_last || (res_load <= 2'd1);
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (accept) begin
      if (in_last) begin
        row_nxt = '0;
        col_nxt = '0;
      end else if (last_col) begin
        row_nxt = row_r + RW'(1);
        col_nxt = '0;
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
    s1_nxt.start     = (row_r == '0) && (col_r == '0);
    s1_nxt.top_row   = (row_r == '0);
    s1_nxt.first_col = (col_r == '0);
    s1_nxt.blocked   = in_ch.blocked;
    s1_nxt.last      = in_last;
    s1_nxt.single    = (rows_eff == ONE) && (cols_eff == ONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // Update stage
  gmpc_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_COLS)) u_col_store (
    .clk  (clk),
    .we   (s1_valid_r),
    .waddr(s1_col_r),
    .wdata(count),
    .raddr(col_r),
    .rdata(ram_rdata)
  );

  assign up   = s1_r.top_row ? '0 : (fwd_hit_r ? fwd_data_r : ram_rdata);
  assign left = s1_r.first_col ? '0 : left_r;

  always_comb begin
    if (s1_r.start) begin
      count = COUNT_W'(1);
    end else if (s1_r.blocked) begin
      count = '0;
    end else begin
      count = up + left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      fwd_hit_r  <= accept && s1_valid_r && (col_r == s1_col_r);
    end
    if (accept) begin
      s1_r     <= s1_nxt;
      s1_col_r <= col_r;
    end
    if (s1_valid_r) begin
      left_r     <= count;
      fwd_data_r <= count;
    end
  end

  // Result buffer: output register plus skid register
  assign res_count = s1_r.single ? '0 : count;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_count_nxt  = out_count_r;
    skid_valid_nxt = skid_valid_r;
    skid_count_nxt = skid_count_r;
    if (res_pop) begin
      out_valid_nxt  = skid_valid_r;
      out_count_nxt  = skid_count_r;
      skid_valid_nxt = 1'b0;
    end
    if (res_push) begin
      if (!out_valid_nxt) begin
        out_valid_nxt = 1'b1;
        out_count_nxt = res_count;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_count_nxt = res_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_count_r  <= out_count_nxt;
    skid_count_r <= skid_count_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.path_count = out_count_r;

  `GMPC_ASSERT_NOW(a_result_room, res_push, !(out_valid_r && skid_valid_r) || out_ch.ready,
    "last cell reached update stage with result buffer full")
  `GMPC_ASSERT_NEXT(a_last_gives_result, res_push, out_valid_r,
    "last cell did not produce a result")
  `GMPC_ASSERT_NOW(a_fwd_needs_stage, fwd_hit_r, s1_valid_r,
    "forwarded column count without a cell in the update stage")
  `GMPC_ASSERT_NEXT(a_last_restarts, accept && in_last && !cfg_we,
    row_r == '0 && col_r == '0, "grid did not restart after last cell")

endmodule

// ===== tb/grid_monotone_path_counter_test.sv =====
// Self-checking testbench for grid_monotone_path_counter: cell requests in, path counts out.
// A scoreboard class predicts each count from the accepted cells. Plain tasks drive the block.
// Depends on gmpc_pkg, gmpc_in_if, gmpc_out_if and the block itself.
module grid_monotone_path_counter_test;
  import gmpc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  class path_count_board;
    localparam int unsigned SIDE_MAX = 16;
    logic [CFG_W-1:0]   rows_reg;
    logic [CFG_W-1:0]   cols_reg;
    logic [COUNT_W-1:0] col_sums [SIDE_MAX];
    logic [COUNT_W-1:0] left_sum;
    logic [3:0]         row_pos;
    logic [3:0]         col_pos;
    logic [COUNT_W-1:0] expected_counts [$];
    int                 errors;
    int                 results;
    int                 cells;

    function new();
      rows_reg = GRID_ROWS_RESET;
      cols_reg = GRID_COLS_RESET;
      errors = 0;
      results = 0;
      cells = 0;
      restart();
    endfunction

    function void restart();
      foreach (col_sums[i]) col_sums[i] = '0;
      left_sum = '0;
      row_pos = '0;
      col_pos = '0;
    endfunction

    function int unsigned span(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > SIDE_MAX) return SIDE_MAX;
      return 32'(v);
    endfunction

    function int unsigned grid_cells();
      return span(rows_reg) * span(cols_reg);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_GRID_ROWS) rows_reg = val;
      else if (idx == REG_GRID_COLS) cols_reg = val;
      restart();
    endfunction

    function void note_cell(logic blk);
      int unsigned rows;
      int unsigned cols;
      logic [COUNT_W-1:0] here;
      logic [COUNT_W-1:0] from_up;
      logic [COUNT_W-1:0] from_left;
      rows = span(rows_reg);
      cols = span(cols_reg);
      cells++;
      if (row_pos >= rows || col_pos >= cols) restart();
      if (row_pos == 0 && col_pos == 0) begin
        here = COUNT_W'(1);
      end else if (blk) begin
        here = '0;
      end else begin
        from_up = (row_pos > 0) ? col_sums[col_pos] : '0;
        from_left = (col_pos > 0) ? left_sum : '0;
        here = from_up + from_left;
      end
      col_sums[col_pos] = here;
      left_sum = here;
      if (row_pos == rows - 1 && col_pos == cols - 1) begin
        if (rows == 1 && cols == 1) here = '0;
        expected_counts = {expected_counts, here};
        restart();
      end else if (col_pos + 1 >= cols) begin
        col_pos = '0;
        row_pos++;
        left_sum = '0;
      end else begin
        col_pos++;
      end
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_count(logic [COUNT_W-1:0] got);
      logic [COUNT_W-1:0] want;
      results++;
      if (expected_counts.size() == 0) begin
        report($sformatf("path_count %0d with no grid pending", got));
      end else begin
        want = expected_counts.pop_front();
        if (got !== want)
          report($sformatf("path_count %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  bit                   steady;
  int                   writes;

  path_count_board sb = new();

  gmpc_in_if  in_ch();
  gmpc_out_if out_ch();

  grid_monotone_path_counter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("grid_monotone_path_counter_test NOT OK");
    $finish;
  end

  function automatic int draw_gap();
    if (steady) return 0;
    return $urandom_range(0, 7);
  endfunction

  initial begin
    int stall;
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_count(out_ch.path_count);
  end

  task automatic send_cell(input logic blk);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.blocked <= blk;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_cell(blk);
  endtask

  task automatic run_grid(input int unsigned n, input int pct);
    repeat (n) send_cell($urandom_range(0, 99) < pct);
  endtask

  // stop sending cells and wait for every pending result to be checked
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.expected_counts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val,
                           input bit last);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (last) cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    writes++;
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return CFG_W'($urandom_range(17, 31));
      2:       return 5'd16;
      default: return CFG_W'($urandom_range(1, 6));
    endcase
  endfunction

  initial begin
    int directed_cells;
    int phase;
    int pct;
    int big_grids;
    logic [CFG_W-1:0] new_rows;
    logic [CFG_W-1:0] new_cols;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.blocked <= 1'b0;
    steady = 0;
    writes = 0;
    big_grids = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset size, start cell flagged blocked (ignored)
    for (int i = 0; i < 72; i++) send_cell(i == 0);
    settle();
    // single cell: no path counted
    write_cfg(REG_GRID_ROWS, 5'd1, 0);
    write_cfg(REG_GRID_COLS, 5'd1, 1);
    send_cell(1'b1);
    send_cell(1'b0);
    settle();
    write_cfg(REG_GRID_ROWS, 5'd0, 0);
    write_cfg(REG_GRID_COLS, 5'd0, 1);
    send_cell(1'b0);
    settle();
    // one row, then blocked end cell
    write_cfg(REG_GRID_ROWS, 5'd1, 0);
    write_cfg(REG_GRID_COLS, 5'd2, 1);
    send_cell(1'b1);
    send_cell(1'b0);
    send_cell(1'b0);
    send_cell(1'b1);
    settle();
    write_cfg(REG_GRID_ROWS, 5'd2, 0);
    write_cfg(REG_GRID_COLS, 5'd1, 1);
    send_cell(1'b0);
    send_cell(1'b0);
    settle();
    // grid abandoned by a write to an unused index
    write_cfg(REG_GRID_COLS, 5'd2, 1);
    send_cell(1'b0);
    send_cell(1'b0);
    settle();
    write_cfg(REG_SPARE_2, 5'h1f, 1);
    send_cell(1'b1);
    send_cell(1'b0);
    send_cell(1'b0);
    send_cell(1'b0);
    settle();
    write_cfg(REG_SPARE_3, 5'h00, 1);
    directed_cells = sb.cells;

    for (phase = 0; sb.cells - directed_cells < 1300; phase++) begin
      steady = ($urandom_range(0, 4) == 0);
      if (phase == 0) begin
        new_rows = 5'd31;
        new_cols = 5'd16;
        pct = 0;
      end else begin
        new_rows = pick_size();
        new_cols = ($urandom_range(0, 3) == 2) ? sb.cols_reg : pick_size();
        case ($urandom_range(0, 4))
          0: pct = 0;
          1: pct = 5;
          2: pct = 15;
          3: pct = 30;
          default: pct = 60;
        endcase
      end
      if (sb.span(new_rows) * sb.span(new_cols) > 64) begin
        if (big_grids >= 6) new_rows = CFG_W'($urandom_range(1, 3));
        else big_grids++;
      end
      if ($urandom_range(0, 3) == 0)
        write_cfg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                  CFG_W'($urandom_range(0, 31)), 0);
      if (new_cols == sb.cols_reg && $urandom_range(0, 1)) begin
        write_cfg(REG_GRID_ROWS, new_rows, 1);
      end else if ($urandom_range(0, 1)) begin
        write_cfg(REG_GRID_ROWS, new_rows, 0);
        write_cfg(REG_GRID_COLS, new_cols, 1);
      end else begin
        write_cfg(REG_GRID_COLS, new_cols, 0);
        write_cfg(REG_GRID_ROWS, new_rows, 1);
      end
      repeat ($urandom_range(1, 3)) run_grid(sb.grid_cells(), pct);
      if ($urandom_range(0, 5) == 0 && sb.grid_cells() > 1)
        run_grid($urandom_range(1, sb.grid_cells() - 1), pct);
      settle();
    end

    steady = 0;
    repeat (8) @(posedge clk);
    if (sb.expected_counts.size() != 0)
      sb.report($sformatf("%0d path counts never arrived", sb.expected_counts.size()));
    $display("Sent %0d cells over %0d random phases with %0d register writes;",
             sb.cells, phase, writes);
    $display("checked %0d path counts, %0d mismatches.", sb.results, sb.errors);
    if (sb.errors == 0) begin
      $display("grid_monotone_path_counter_test OK");
    end else begin
      $display("grid_monotone_path_counter_test NOT OK");
    end
    $finish;
  end
endmodule
